// ===== sv/ppp_tx_pkg.sv =====
// Package for the PPP asynchronous HDLC transmit framer.
// Holds the byte and run-entry types, the framing constants and the FCS-16 byte update.
// No dependencies.
package ppp_tx_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;

    localparam t_byte FLAG_BYTE = 8'h7E;
    localparam t_byte ESC_BYTE  = 8'h7D;
    localparam t_byte ESC_XOR   = 8'h20;
    localparam t_crc  CRC_POLY  = 16'h8408;
    localparam t_crc  CRC_SEED  = 16'hFFFF;

    // Longest run one item can cause: opening flag, escaped data byte,
    // two escaped FCS bytes and the closing flag.
    localparam int RUN_MAX = 8;
    localparam int RUN_IW  = $clog2(RUN_MAX);
    localparam int RUN_CW  = $clog2(RUN_MAX + 1);

    typedef struct packed {
        logic  closed;
        t_byte lbyte;
    } t_entry;

    typedef struct packed {
        logic  two;
        t_byte b0;
        t_byte b1;
    } t_esc;

    // Reflected CRC-16 update over one byte.
    function automatic t_crc crc_byte(input t_crc crc, input t_byte b);
        t_crc v;
        v = {8'h00, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++) begin
            if (v[0]) begin
                v = (v >> 1) ^ CRC_POLY;
            end else begin
                v = v >> 1;
            end
        end
        return v ^ {8'h00, crc[15:8]};
    endfunction

    // Control characters and the two reserved codes go out as an escape pair.
    function automatic t_esc escape(input t_byte b);
        t_esc e;
        e.two = (b < 8'h20) || (b == ESC_BYTE) || (b == FLAG_BYTE);
        e.b0  = e.two ? ESC_BYTE : b;
        e.b1  = b ^ ESC_XOR;
        return e;
    endfunction

endpackage

// ===== sv/ppp_hdlc_tx_framer.sv =====
// PPP asynchronous HDLC transmit framer: flags, byte escaping and FCS-16.
// The first line byte of an item is offered from the run buffer once the item has moved on from the input register.
// Throughput: one line byte per cycle while i_out_ready is high; an item expands to 1 to 8
// line bytes in the run buffer, while the input register takes the next item. Synchronous
// active-low reset empties both stages, closes any frame and reseeds the CRC to 0xFFFF.
module ppp_hdlc_tx_framer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppp_tx_pkg::t_byte  i_data_byte,
    input  logic               i_frame_start,
    input  logic               i_frame_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ppp_tx_pkg::t_byte  o_line_byte,
    output logic               o_run_last,
    output logic               o_frame_closed
);
    import ppp_tx_pkg::*;

    // Input register.
    logic        r_a_valid;
    t_byte       r_a_byte;
    logic        r_a_start;
    logic        r_a_end;

    // Framing state.
    t_crc        r_crc;
    logic        r_in_frame;

    // Run buffer: entry 0 is on the line, the rest shift down as bytes are taken.
    t_entry      r_run [RUN_MAX];
    logic [RUN_CW-1:0] r_cnt;

    logic        move;
    logic        out_take;
    logic        opening;
    t_crc        crc_base;
    t_crc        crc_new;
    t_crc        fcs;
    t_esc        e_data;
    t_esc        e_lo;
    t_esc        e_hi;
    t_entry      n_run [RUN_MAX];
    logic [RUN_CW-1:0] n_cnt;

    assign out_take   = o_out_valid && i_out_ready;
    assign move       = r_a_valid && ((r_cnt == '0) ||
                        ((r_cnt == RUN_CW'(1)) && i_out_ready));
    assign o_in_ready = !r_a_valid || move;

    assign opening  = r_a_start || !r_in_frame;
    assign crc_base = opening ? CRC_SEED : r_crc;
    assign crc_new  = crc_byte(crc_base, r_a_byte);
    assign fcs      = ~crc_new;
    assign e_data   = escape(r_a_byte);
    assign e_lo     = escape(fcs[7:0]);
    assign e_hi     = escape(fcs[15:8]);

    // Pack the pieces of the run one after another.
    always_comb begin
        logic [RUN_CW-1:0] k;
        k = '0;
        for (int i = 0; i < RUN_MAX; i++) begin
            n_run[i] = '0;
        end
        if (opening) begin
            n_run[k[RUN_IW-1:0]] = '{closed: 1'b0, lbyte: FLAG_BYTE};
            k = k + RUN_CW'(1);
        end
        n_run[k[RUN_IW-1:0]] = '{closed: 1'b0, lbyte: e_data.b0};
        n_run[k[RUN_IW-1:0] + RUN_IW'(1)] = '{closed: 1'b0, lbyte: e_data.b1};
        k = k + RUN_CW'(1) + RUN_CW'(e_data.two);
        if (r_a_end) begin
            n_run[k[RUN_IW-1:0]] = '{closed: 1'b0, lbyte: e_lo.b0};
            n_run[k[RUN_IW-1:0] + RUN_IW'(1)] = '{closed: 1'b0, lbyte: e_lo.b1};
            k = k + RUN_CW'(1) + RUN_CW'(e_lo.two);
            n_run[k[RUN_IW-1:0]] = '{closed: 1'b0, lbyte: e_hi.b0};
            n_run[k[RUN_IW-1:0] + RUN_IW'(1)] = '{closed: 1'b0, lbyte: e_hi.b1};
            k = k + RUN_CW'(1) + RUN_CW'(e_hi.two);
            n_run[k[RUN_IW-1:0]] = '{closed: 1'b1, lbyte: FLAG_BYTE};
            k = k + RUN_CW'(1);
        end
        n_cnt = k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_crc      <= CRC_SEED;
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
        end else begin
            if (o_in_ready) begin
                r_a_valid <= i_in_valid;
            end
            if (move) begin
                r_cnt      <= n_cnt;
                r_in_frame <= !r_a_end;
                r_crc      <= r_a_end ? CRC_SEED : crc_new;
            end else if (out_take) begin
                r_cnt <= r_cnt - RUN_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_byte  <= i_data_byte;
            r_a_start <= i_frame_start;
            r_a_end   <= i_frame_end;
        end
        if (move) begin
            r_run <= n_run;
        end else if (out_take) begin
            for (int i = 0; i < RUN_MAX - 1; i++) begin
                r_run[i] <= r_run[i + 1];
            end
        end
    end

    assign o_out_valid    = (r_cnt != '0);
    assign o_line_byte    = r_run[0].lbyte;
    assign o_run_last     = (r_cnt == RUN_CW'(1));
    assign o_frame_closed = r_run[0].closed;

    // The closing flag is always the last byte of its item's run.
    a_closed_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_closed) |-> (o_run_last && (o_line_byte == FLAG_BYTE)))
        else $error("closing flag not last or not a flag");

    // A frame end closes the frame and reseeds the CRC.
    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_a_end) |=> (!r_in_frame && (r_crc == CRC_SEED)))
        else $error("frame state not cleared after frame end");

    // A new run is loaded only into an empty or draining buffer.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |-> ((r_cnt == '0) || (o_run_last && i_out_ready)))
        else $error("run buffer overwritten before it drained");

    // A run that waits on the line does not change.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_line_byte)))
        else $error("line byte changed while stalled");

endmodule
